>>> sv/rdi_pkg.sv
// Package for the ray/disk intersection pipeline: field widths, fixed-point
// constants, the payload and stage structures and the saturation helper.
// Depends on nothing; every other file of the block imports it.
package rdi_pkg;

    localparam int FIX_W      = 32;                  // Q16.16 coordinate
    localparam int FRAC_W     = 16;                  // fractional bits
    localparam int RSQ_W      = 48;                  // Q32.16 squared radius
    localparam int PROD_W     = 2 * FIX_W;           // exact Q32.32 product
    localparam int SUM_W      = PROD_W + 2;          // sum of three products
    localparam int DOT_W      = SUM_W - FRAC_W;      // floored dot product
    localparam int MAG_W      = DOT_W - 1;           // magnitude of a dot product
    localparam int QUO_W      = FIX_W - 1;           // quotient bits of t
    localparam int DIV_STAGES = QUO_W;               // one quotient bit a stage
    localparam int PRE_SHIFT  = QUO_W - FRAC_W;      // saturation test shift
    localparam int SHIFT_W    = MAG_W - PRE_SHIFT;   // bits of the first remainder
    localparam int PT_W       = PROD_W - FRAC_W + 1; // origin plus scaled direction
    localparam int IN_W       = 9 * FIX_W + RSQ_W;   // 336 bits, whole bytes
    localparam int OUT_BITS   = 1 + 3 * FIX_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    // 0.001 rounded to Q16.16.
    localparam logic [FIX_W-1:0] EPS_Q16 = FIX_W'(66);

    typedef logic signed [FIX_W-1:0] fix_t;

    typedef struct packed {
        fix_t x;
        fix_t y;
        fix_t z;
    } vec3_t;

    // Fields that ride along the pipeline untouched until the point stage.
    typedef struct packed {
        vec3_t            o;
        vec3_t            d;
        logic [RSQ_W-1:0] rsq;
    } side_t;

    // One stage of the restoring divider.
    typedef struct packed {
        logic             vld;
        logic             go;    // ray points towards the disk plane
        logic             sat;   // t saturates
        logic [MAG_W-1:0] rem;   // partial remainder
        logic [QUO_W-1:0] nbits; // dividend bits still to shift in
        logic [MAG_W-1:0] den;   // |direction . normal|
        logic [QUO_W-1:0] quo;   // quotient so far
        side_t            side;
    } div_st_t;

    typedef struct packed {
        logic  vld;
        logic  hit;
        vec3_t pt;
    } res_t;

    function automatic fix_t sat_fix(input logic [PT_W-1:0] v);
        fix_t r;
        if (!v[PT_W-1] && (|v[PT_W-2:FIX_W-1])) begin
            r = {1'b0, {(FIX_W-1){1'b1}}};
        end else if (v[PT_W-1] && !(&v[PT_W-2:FIX_W-1])) begin
            r = {1'b1, {(FIX_W-1){1'b0}}};
        end else begin
            r = v[FIX_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/rdi_dot.sv
// Two-stage three-term dot product of Q16.16 vectors, floored to Q34.16.
// Depends on rdi_pkg.
module rdi_dot (
    input  logic                              aclk,
    input  logic                              en,
    input  rdi_pkg::vec3_t                    a,
    input  rdi_pkg::vec3_t                    b,
    output logic signed [rdi_pkg::DOT_W-1:0] dot
);
    import rdi_pkg::*;

    logic signed [PROD_W-1:0] prod_reg [3];
    logic        [SUM_W-1:0]  sum;
    logic        [DOT_W-1:0]  dot_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= $signed(a.x) * $signed(b.x);
            prod_reg[1] <= $signed(a.y) * $signed(b.y);
            prod_reg[2] <= $signed(a.z) * $signed(b.z);
            dot_reg     <= sum[SUM_W-1:FRAC_W];
        end
    end

    // The exact sum is formed first, so flooring happens once.
    assign sum = {{2{prod_reg[0][PROD_W-1]}}, prod_reg[0]}
               + {{2{prod_reg[1][PROD_W-1]}}, prod_reg[1]}
               + {{2{prod_reg[2][PROD_W-1]}}, prod_reg[2]};

    assign dot = $signed(dot_reg);

endmodule

>>> sv/rdi_front.sv
// Front end: both dot products, the miss tests on their signs, the
// magnitudes and the set-up of the divider. Depends on rdi_pkg, rdi_dot.
module rdi_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  rdi_pkg::side_t   side_in,
    input  rdi_pkg::vec3_t   n_in,
    output rdi_pkg::div_st_t st_out
);
    import rdi_pkg::*;

    logic signed [DOT_W-1:0] den;
    logic signed [DOT_W-1:0] don;
    logic [DOT_W-1:0]        den_abs;
    logic [DOT_W-1:0]        don_abs;

    logic             vld1_reg, vld2_reg, vld3_reg;
    side_t            side1_reg, side2_reg, side3_reg;
    logic             go3_reg;
    logic [MAG_W-1:0] an3_reg, ad3_reg;
    div_st_t          st4_reg;
    div_st_t          st4_next;

    rdi_dot u_dot_dn (.aclk(aclk), .en(en), .a(side_in.d), .b(n_in), .dot(den));
    rdi_dot u_dot_on (.aclk(aclk), .en(en), .a(side_in.o), .b(n_in), .dot(don));

    // num is minus (origin . normal), so a usable ray has opposite signs here.
    assign den_abs = den[DOT_W-1] ? DOT_W'(-den) : DOT_W'(den);
    assign don_abs = don[DOT_W-1] ? DOT_W'(-don) : DOT_W'(don);

    always_comb begin
        st4_next       = '0;
        st4_next.vld   = vld3_reg;
        st4_next.go    = go3_reg;
        st4_next.sat   = {{PRE_SHIFT{1'b0}}, an3_reg} >= {ad3_reg, {PRE_SHIFT{1'b0}}};
        st4_next.rem   = {{PRE_SHIFT{1'b0}}, an3_reg[MAG_W-1:PRE_SHIFT]};
        st4_next.nbits = {an3_reg[PRE_SHIFT-1:0], {FRAC_W{1'b0}}};
        st4_next.den   = ad3_reg;
        st4_next.quo   = '0;
        st4_next.side  = side3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            st4_reg.vld <= 1'b0;
        end else if (en) begin
            vld1_reg    <= in_vld;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            st4_reg.vld <= st4_next.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            go3_reg   <= (den != '0) && (don != '0) && (den[DOT_W-1] != don[DOT_W-1]);
            an3_reg   <= don_abs[MAG_W-1:0];
            ad3_reg   <= den_abs[MAG_W-1:0];
            st4_reg.go    <= st4_next.go;
            st4_reg.sat   <= st4_next.sat;
            st4_reg.rem   <= st4_next.rem;
            st4_reg.nbits <= st4_next.nbits;
            st4_reg.den   <= st4_next.den;
            st4_reg.quo   <= st4_next.quo;
            st4_reg.side  <= st4_next.side;
        end
    end

    assign st_out = st4_reg;

endmodule

>>> sv/rdi_div.sv
// Pipelined restoring divider for t, one quotient bit per register stage.
// Depends on rdi_pkg.
module rdi_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  rdi_pkg::div_st_t st_in,
    output rdi_pkg::div_st_t st_out
);
    import rdi_pkg::*;

    function automatic div_st_t div_step(input div_st_t cur);
        div_st_t        nxt;
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           take;
        nxt   = cur;
        trial = {cur.rem, cur.nbits[QUO_W-1]};
        diff  = trial - {1'b0, cur.den};
        take  = trial >= {1'b0, cur.den};
        nxt.rem   = take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        nxt.nbits = {cur.nbits[QUO_W-2:0], 1'b0};
        nxt.quo   = {cur.quo[QUO_W-2:0], take};
        return nxt;
    endfunction

    div_st_t stage_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        div_st_t prev;
        if (g == 0) begin : g_first
            assign prev = st_in;
        end else begin : g_rest
            assign prev = stage_reg[g-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg[g].vld <= 1'b0;
            end else if (en) begin
                stage_reg[g].vld <= prev.vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[g].go    <= div_step(prev).go;
                stage_reg[g].sat   <= div_step(prev).sat;
                stage_reg[g].rem   <= div_step(prev).rem;
                stage_reg[g].nbits <= div_step(prev).nbits;
                stage_reg[g].den   <= div_step(prev).den;
                stage_reg[g].quo   <= div_step(prev).quo;
                stage_reg[g].side  <= div_step(prev).side;
            end
        end
    end

    assign st_out = stage_reg[DIV_STAGES-1];

endmodule

>>> sv/rdi_point.sv
// Back end: t minus epsilon, the hit point with saturation, the squared
// distance and the radius test, over five register stages. Depends on rdi_pkg.
module rdi_point (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  rdi_pkg::div_st_t st_in,
    output rdi_pkg::res_t    res
);
    import rdi_pkg::*;

    logic [QUO_W-1:0] t_q;

    logic             vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic             ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    side_t            side1_reg;
    vec3_t            o2_reg;
    logic [RSQ_W-1:0] rsq2_reg, rsq3_reg, rsq4_reg;
    logic [FIX_W-1:0] s1_reg;
    logic signed [PROD_W-1:0] mul2_reg [3];
    vec3_t            pt3_reg, pt4_reg;
    logic [PROD_W-1:0] sq4_reg [3];
    logic [SUM_W-1:0] len_sq;
    logic             hit;
    res_t             res_reg;

    function automatic logic [PT_W-1:0] add_scaled(input fix_t o,
                                                   input logic [PROD_W-1:0] p);
        return {{(PT_W-FIX_W){o[FIX_W-1]}}, o} + {p[PROD_W-1], p[PROD_W-1:FRAC_W]};
    endfunction

    assign t_q    = st_in.sat ? {QUO_W{1'b1}} : st_in.quo;
    assign len_sq = {2'b00, sq4_reg[0]} + {2'b00, sq4_reg[1]} + {2'b00, sq4_reg[2]};
    assign hit    = ok4_reg && (len_sq <= {2'b00, rsq4_reg, {FRAC_W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            res_reg.vld <= 1'b0;
        end else if (en) begin
            vld1_reg    <= st_in.vld;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            vld4_reg    <= vld3_reg;
            res_reg.vld <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // A quotient of zero means the disk plane lies at the origin to within one LSB of t.
            ok1_reg   <= st_in.go && (t_q != '0);
            s1_reg    <= {1'b0, t_q} - EPS_Q16;
            side1_reg <= st_in.side;

            ok2_reg     <= ok1_reg;
            o2_reg      <= side1_reg.o;
            rsq2_reg    <= side1_reg.rsq;
            mul2_reg[0] <= $signed(side1_reg.d.x) * $signed(s1_reg);
            mul2_reg[1] <= $signed(side1_reg.d.y) * $signed(s1_reg);
            mul2_reg[2] <= $signed(side1_reg.d.z) * $signed(s1_reg);

            ok3_reg   <= ok2_reg;
            rsq3_reg  <= rsq2_reg;
            pt3_reg.x <= sat_fix(add_scaled(o2_reg.x, mul2_reg[0]));
            pt3_reg.y <= sat_fix(add_scaled(o2_reg.y, mul2_reg[1]));
            pt3_reg.z <= sat_fix(add_scaled(o2_reg.z, mul2_reg[2]));

            ok4_reg    <= ok3_reg;
            rsq4_reg   <= rsq3_reg;
            pt4_reg    <= pt3_reg;
            sq4_reg[0] <= $signed(pt3_reg.x) * $signed(pt3_reg.x);
            sq4_reg[1] <= $signed(pt3_reg.y) * $signed(pt3_reg.y);
            sq4_reg[2] <= $signed(pt3_reg.z) * $signed(pt3_reg.z);

            res_reg.hit <= hit;
            res_reg.pt  <= hit ? pt4_reg : '0;
        end
    end

    assign res = res_reg;

endmodule

>>> sv/ray_disk_intersect.sv
// Ray/disk intersection test in Q16.16: one ray accepted per clock cycle while
// s_tready is high. A beat passes 4 front stages, 31 divider stages, 5 point
// stages and 1 output register; the 31-stage divider pipeline sets the depth.
// Reset: aresetn is synchronous and active low; it clears every valid bit and the
// skid stage, so no result beat is pending afterwards. Payload is not reset.
module ray_disk_intersect (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input channel. s_tdata fields from bit 0 up: origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z (32 bits each, signed),
    // radius_sq (48 bits, unsigned).
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [rdi_pkg::IN_W-1:0]   s_tdata,
    // Result channel. m_tdata fields from bit 0 up: hit (1 bit), point_x,
    // point_y, point_z (32 bits each, signed), then 7 zero bits of padding.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [rdi_pkg::OUT_W-1:0]  m_tdata
);
    import rdi_pkg::*;

    // The whole pipeline moves together on en. A skid register behind the
    // output register catches the beat that is in flight when the downstream
    // side stalls, so s_tready depends only on our own registers.
    logic    en;
    side_t   side_in;
    vec3_t   n_in;
    div_st_t front_st;
    div_st_t div_st;
    res_t    res;

    logic    m_vld_reg;
    res_t    out_reg;
    logic    skid_vld_reg;
    res_t    skid_reg;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // Unpack the input beat.
    assign side_in.o.x = s_tdata[0*FIX_W +: FIX_W];
    assign side_in.o.y = s_tdata[1*FIX_W +: FIX_W];
    assign side_in.o.z = s_tdata[2*FIX_W +: FIX_W];
    assign side_in.d.x = s_tdata[3*FIX_W +: FIX_W];
    assign side_in.d.y = s_tdata[4*FIX_W +: FIX_W];
    assign side_in.d.z = s_tdata[5*FIX_W +: FIX_W];
    assign n_in.x      = s_tdata[6*FIX_W +: FIX_W];
    assign n_in.y      = s_tdata[7*FIX_W +: FIX_W];
    assign n_in.z      = s_tdata[8*FIX_W +: FIX_W];
    assign side_in.rsq = s_tdata[9*FIX_W +: RSQ_W];

    // Dot products, the parallel and behind-origin tests and divider set-up.
    rdi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .side_in (side_in),
        .n_in    (n_in),
        .st_out  (front_st)
    );

    // t = |num| * 2^16 / |denom|, one quotient bit per stage.
    rdi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .st_in   (front_st),
        .st_out  (div_st)
    );

    // Hit point, saturation and the radius test; misses come out as zero.
    rdi_point u_point (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .st_in   (div_st),
        .res     (res)
    );

    // Output register with skid stage. When the output is free or being taken,
    // it loads the skid beat if there is one, else the pipeline's result.
    // Otherwise a fresh result parks in the skid register and freezes the pipe.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                m_vld_reg    <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_vld_reg <= en && res.vld;
            end
        end else if (en && res.vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_vld_reg || m_tready) begin
            out_reg <= skid_vld_reg ? skid_reg : res;
        end
        if (en && res.vld && m_vld_reg && !m_tready) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}},
                       out_reg.pt.z, out_reg.pt.y, out_reg.pt.x, out_reg.hit};

endmodule

>>> sv/rdi_checker.sv
// Port-level checker for ray_disk_intersect and the bind that attaches it.
// Depends on rdi_pkg for the channel widths.
module rdi_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [rdi_pkg::OUT_W-1:0] m_tdata
);
    import rdi_pkg::*;

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present straight after reset");

    // A miss carries a zero point.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_BITS-1:1] == '0)
        else $error("miss with a non-zero point");

    // Input back-pressure only happens when the output holds a beat.
    a_bp: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with nothing at the output");

    // Padding above the last field stays zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:OUT_BITS] == '0)
        else $error("padding bits set in result beat");

endmodule

bind ray_disk_intersect rdi_checker u_rdi_checker (.*);
